@@ rtl/lfim_pkg.sv @@
// shared constants, codes and types for the inode map engine
package lfim_pkg;

  // table and log geometry
  localparam int unsigned MAX_INODES   = 256;
  localparam int unsigned IDX_W        = $clog2(MAX_INODES);
  localparam int unsigned FLASH_BYTES  = 16777216;
  localparam int unsigned HEADER_BYTES = 64;
  localparam int unsigned SLOT_COUNT   = 64;

  // field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned INUM_W  = 16;
  localparam int unsigned VER_W   = 32;
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned TAIL_W  = 25;
  localparam int unsigned SLOT_W  = 7;
  localparam int unsigned NFREE_W = 9;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned NEED_W  = TAIL_W + 1;
  localparam int unsigned ENTRY_W = ADDR_W + VER_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_SCAN   = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
  localparam logic [OP_W-1:0] OP_LOAD   = 3'd3;
  localparam logic [OP_W-1:0] OP_FORMAT = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_STALE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 3'd2;
  localparam logic [STAT_W-1:0] ST_INVALID  = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVER_CAP = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the input item and start the table read
    logic execute;  // apply the op and load the result register
  } cmd_t;

endpackage

@@ rtl/lfim_ram.sv @@
// generic single-port-write, registered-read ram
module lfim_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lfim_ctrl.sv @@
// sequencing state machine and result handshake for the inode map engine
module lfim_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lfim_pkg::cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  // result register can take a new value when empty or drained this cycle
  assign slot_free = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          cmd_o.execute = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result valid tracking
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/lfim_datapath.sv @@
// inode table, log pointers and result register for the inode map engine
module lfim_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lfim_pkg::cmd_t                      cmd_i,
  input  logic [lfim_pkg::OP_W-1:0]           op_i,
  input  logic [lfim_pkg::INUM_W-1:0]         inode_number_i,
  input  logic [lfim_pkg::VER_W-1:0]          record_version_i,
  input  logic [lfim_pkg::ADDR_W-1:0]         record_address_i,
  input  logic [lfim_pkg::ADDR_W-1:0]         payload_bytes_i,
  input  logic [lfim_pkg::TAIL_W-1:0]         tail_value_i,
  input  logic [lfim_pkg::SLOT_W-1:0]         slot_value_i,
  output logic [lfim_pkg::STAT_W-1:0]         status_o,
  output logic [lfim_pkg::ADDR_W-1:0]         entry_address_o,
  output logic [lfim_pkg::VER_W-1:0]          entry_version_o,
  output logic [lfim_pkg::TAIL_W-1:0]         tail_now_o,
  output logic [lfim_pkg::ADDR_W-1:0]         head_now_o,
  output logic [lfim_pkg::SLOT_W-1:0]         slot_now_o,
  output logic                                slots_erased_o,
  output logic [lfim_pkg::NFREE_W-1:0]        next_free_inode_o
);

  // latched input item
  logic [lfim_pkg::OP_W-1:0]   op_q;
  logic [lfim_pkg::INUM_W-1:0] inum_q;
  logic [lfim_pkg::VER_W-1:0]  ver_q;
  logic [lfim_pkg::ADDR_W-1:0] addr_q;
  logic [lfim_pkg::ADDR_W-1:0] payload_q;
  logic [lfim_pkg::TAIL_W-1:0] tval_q;
  logic [lfim_pkg::SLOT_W-1:0] sval_q;

  // architectural state
  logic [lfim_pkg::MAX_INODES-1:0] valid_q, valid_d;
  logic [lfim_pkg::IDX_W-1:0]      highest_q, highest_d;
  logic [lfim_pkg::ADDR_W-1:0]     head_q, head_d;
  logic [lfim_pkg::TAIL_W-1:0]     tail_q, tail_d;
  logic [lfim_pkg::SLOT_W-1:0]     slot_q, slot_d;

  // result register
  logic [lfim_pkg::STAT_W-1:0]  res_status_q, res_status_d;
  logic [lfim_pkg::ADDR_W-1:0]  res_addr_q, res_addr_d;
  logic [lfim_pkg::VER_W-1:0]   res_ver_q, res_ver_d;
  logic                         res_erased_q, res_erased_d;

  // table access
  logic                          ram_we;
  logic [lfim_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [lfim_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [lfim_pkg::ADDR_W-1:0]   new_addr;
  logic [lfim_pkg::ADDR_W-1:0]   old_addr;
  logic [lfim_pkg::VER_W-1:0]    old_ver;
  logic [lfim_pkg::IDX_W-1:0]    idx;
  logic                          in_range;
  logic                          above;
  logic                          entry_valid;
  logic                          replace;
  logic [lfim_pkg::NEED_W-1:0]   need;
  logic                          no_space;

  lfim_ram #(
    .WIDTH (lfim_pkg::ENTRY_W),
    .DEPTH (lfim_pkg::MAX_INODES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (inode_number_i[lfim_pkg::IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // capture the item on transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_i;
      inum_q    <= inode_number_i;
      ver_q     <= record_version_i;
      addr_q    <= record_address_i;
      payload_q <= payload_bytes_i;
      tval_q    <= tail_value_i;
      sval_q    <= slot_value_i;
    end
  end

  // decode of the stored entry and the space check
  assign idx         = inum_q[lfim_pkg::IDX_W-1:0];
  assign in_range    = ({1'b0, inum_q} < (lfim_pkg::INUM_W + 1)'(lfim_pkg::MAX_INODES));
  assign above       = idx > highest_q;
  assign entry_valid = valid_q[idx];
  assign old_addr    = ram_rdata[lfim_pkg::ENTRY_W-1:lfim_pkg::VER_W];
  assign old_ver     = ram_rdata[lfim_pkg::VER_W-1:0];
  assign replace     = above || !entry_valid || (old_ver < ver_q);
  assign need        = {1'b0, tail_q} + lfim_pkg::NEED_W'(lfim_pkg::HEADER_BYTES)
                     + lfim_pkg::NEED_W'(payload_q);
  assign no_space    = need > lfim_pkg::NEED_W'(lfim_pkg::FLASH_BYTES);
  assign new_addr    = (op_q == lfim_pkg::OP_APPEND) ? tail_q[lfim_pkg::ADDR_W-1:0] : addr_q;
  assign ram_wdata   = {new_addr, ver_q};

  // op execution
  always_comb begin
    valid_d      = valid_q;
    highest_d    = highest_q;
    head_d       = head_q;
    tail_d       = tail_q;
    slot_d       = slot_q;
    ram_we       = 1'b0;
    res_status_d = lfim_pkg::ST_OK;
    res_addr_d   = '0;
    res_ver_d    = '0;
    res_erased_d = 1'b0;
    if (cmd_i.execute) begin
      case (op_q) inside
        lfim_pkg::OP_SCAN, lfim_pkg::OP_APPEND: begin
          if ((op_q == lfim_pkg::OP_APPEND) && no_space) begin
            res_status_d = lfim_pkg::ST_NO_SPACE;
          end else if (!in_range) begin
            res_status_d = lfim_pkg::ST_OVER_CAP;
          end else begin
            if (replace) begin
              ram_we       = 1'b1;
              valid_d[idx] = 1'b1;
              if (above) begin
                highest_d = idx;
              end
              res_addr_d = new_addr;
              res_ver_d  = ver_q;
            end else begin
              res_status_d = lfim_pkg::ST_STALE;
              res_addr_d   = old_addr;
              res_ver_d    = old_ver;
            end
            // tail advance and slot counter for appends
            if (op_q == lfim_pkg::OP_APPEND) begin
              tail_d = need[lfim_pkg::TAIL_W-1:0];
              if (slot_q >= lfim_pkg::SLOT_W'(lfim_pkg::SLOT_COUNT)) begin
                res_erased_d = 1'b1;
                slot_d       = lfim_pkg::SLOT_W'(1);
              end else begin
                slot_d = slot_q + lfim_pkg::SLOT_W'(1);
              end
            end
          end
        end
        lfim_pkg::OP_LOOKUP: begin
          if (!in_range) begin
            res_status_d = lfim_pkg::ST_OVER_CAP;
          end else if (above || !entry_valid) begin
            res_status_d = lfim_pkg::ST_INVALID;
          end else begin
            res_addr_d = old_addr;
            res_ver_d  = old_ver;
          end
        end
        lfim_pkg::OP_LOAD: begin
          if (sval_q == '0) begin
            head_d = '0;
            tail_d = '0;
            slot_d = '0;
          end else begin
            head_d = addr_q;
            tail_d = tval_q;
            slot_d = (sval_q > lfim_pkg::SLOT_W'(lfim_pkg::SLOT_COUNT))
                   ? lfim_pkg::SLOT_W'(lfim_pkg::SLOT_COUNT) : sval_q;
          end
        end
        lfim_pkg::OP_FORMAT: begin
          valid_d   = '0;
          highest_d = '0;
          head_d    = '0;
          tail_d    = '0;
          slot_d    = '0;
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      highest_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      slot_q    <= '0;
    end else begin
      valid_q   <= valid_d;
      highest_q <= highest_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      slot_q    <= slot_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      res_status_q <= res_status_d;
      res_addr_q   <= res_addr_d;
      res_ver_q    <= res_ver_d;
      res_erased_q <= res_erased_d;
    end
  end

  // pointers only change on execute, so they match the held result
  assign status_o          = res_status_q;
  assign entry_address_o   = res_addr_q;
  assign entry_version_o   = res_ver_q;
  assign tail_now_o        = tail_q;
  assign head_now_o        = head_q;
  assign slot_now_o        = slot_q;
  assign slots_erased_o    = res_erased_q;
  assign next_free_inode_o = lfim_pkg::NFREE_W'({1'b0, highest_q}) + lfim_pkg::NFREE_W'(1);

endmodule

@@ rtl/log_flash_inode_map_engine_core.sv @@
// top level of the flash log inode map engine
// Each op runs as a read and an update: in the transfer cycle the inode's table
// entry is read from the table ram, which has one write port and one
// registered read port, and in the update state the
// registered entry is compared, written back if needed and the pointers and
// result register are updated. The next op is taken the cycle after that,
// even while the previous result is still held by a stalled output; the
// update cycle waits only when that result has not yet been taken. Format
// clears all the valid bits together, and there is no clearing pass after
// reset. The pointer outputs reflect the state after the most recent op.
module log_flash_inode_map_engine_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lfim_pkg::OP_W-1:0]           op_i,
  input  logic [lfim_pkg::INUM_W-1:0]         inode_number_i,
  input  logic [lfim_pkg::VER_W-1:0]          record_version_i,
  input  logic [lfim_pkg::ADDR_W-1:0]         record_address_i,
  input  logic [lfim_pkg::ADDR_W-1:0]         payload_bytes_i,
  input  logic [lfim_pkg::TAIL_W-1:0]         tail_value_i,
  input  logic [lfim_pkg::SLOT_W-1:0]         slot_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lfim_pkg::STAT_W-1:0]         status_o,
  output logic [lfim_pkg::ADDR_W-1:0]         entry_address_o,
  output logic [lfim_pkg::VER_W-1:0]          entry_version_o,
  output logic [lfim_pkg::TAIL_W-1:0]         tail_now_o,
  output logic [lfim_pkg::ADDR_W-1:0]         head_now_o,
  output logic [lfim_pkg::SLOT_W-1:0]         slot_now_o,
  output logic                                slots_erased_o,
  output logic [lfim_pkg::NFREE_W-1:0]        next_free_inode_o
);

  lfim_pkg::cmd_t cmd;

  // sequencing
  lfim_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // table and pointers
  lfim_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .op_i              (op_i),
    .inode_number_i    (inode_number_i),
    .record_version_i  (record_version_i),
    .record_address_i  (record_address_i),
    .payload_bytes_i   (payload_bytes_i),
    .tail_value_i      (tail_value_i),
    .slot_value_i      (slot_value_i),
    .status_o          (status_o),
    .entry_address_o   (entry_address_o),
    .entry_version_o   (entry_version_o),
    .tail_now_o        (tail_now_o),
    .head_now_o        (head_now_o),
    .slot_now_o        (slot_now_o),
    .slots_erased_o    (slots_erased_o),
    .next_free_inode_o (next_free_inode_o)
  );

endmodule

@@ rtl/lfim_checker.sv @@
// port-level checks for the inode map engine, bound to the top level
module lfim_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [lfim_pkg::STAT_W-1:0]   status_o,
  input logic [lfim_pkg::SLOT_W-1:0]   slot_now_o,
  input logic                          slots_erased_o,
  input logic [lfim_pkg::NFREE_W-1:0]  next_free_inode_o
);

  // a held result keeps its status
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("stalled result changed");

  // the update cycle follows every input transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken during update cycle");

  // an erase restarts the slot counter at one
  a_erase_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slots_erased_o |-> slot_now_o == lfim_pkg::SLOT_W'(1))
    else $error("slot counter wrong after erase");

  // slot counter never passes the slot store size
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> slot_now_o <= lfim_pkg::SLOT_W'(lfim_pkg::SLOT_COUNT))
    else $error("slot counter out of range");

  // next free inode is never zero and erase only on an ok or stale append
  a_nfree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> next_free_inode_o != '0 &&
      (!slots_erased_o || status_o == lfim_pkg::ST_OK || status_o == lfim_pkg::ST_STALE))
    else $error("result fields inconsistent");

endmodule

bind log_flash_inode_map_engine_core lfim_checker u_lfim_checker (.*);
